// ----- design/efsg_pkg.sv -----
// Shared definitions for the filled ellipse span generator.
// Holds field widths, register and action codes, sequencer states and the span struct.
// No dependencies; every other design file refers to it by scoped names.
package efsg_pkg;

	// Defaults for the top-level parameters.
	localparam int RADIUS_BITS_DEF = 10;
	localparam int ACC_BITS_DEF    = 40;

	// Fixed field widths of the stream words.
	localparam int COORD_W  = 16;
	localparam int ROW_W    = 17;
	localparam int CLR_W    = 32;
	localparam int DIM_W    = 13;
	localparam int RAD_IN_W = 10;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_TUSER_W = 2;
	localparam int CFG_INDEX_W = 2;

	// Bit positions of the result flags in the output tuser.
	localparam int OUT_SPAN_BIT = 0;
	localparam int OUT_DONE_BIT = 1;

	// Configuration register indexes and reset values.
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [DIM_W-1:0]       WIDTH_RESET      = 13'd640;
	localparam logic [DIM_W-1:0]       HEIGHT_RESET     = 13'd480;

	// Input word kinds.
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// Stage of the ellipse algorithm.
	typedef enum logic [1:0] {
		STG_IDLE = 2'd0,
		STG_ONE  = 2'd1,
		STG_TWO  = 2'd2
	} stage_t;

	// Sequencer states; the MUL_* states each own one pass through the multiplier.
	typedef enum logic [2:0] {
		SEQ_IDLE   = 3'd0,
		SEQ_MUL_AA = 3'd1,
		SEQ_MUL_BB = 3'd2,
		SEQ_MUL_CX = 3'd3,
		SEQ_MUL_SX = 3'd4,
		SEQ_MUL_CY = 3'd5,
		SEQ_MUL_SY = 3'd6
	} seq_state_t;

	// One clipped span pair as it leaves the span formatter.
	typedef struct packed {
		logic [CLR_W-1:0]          span_color;
		logic signed [ROW_W-1:0]   span_right;
		logic [COORD_W-1:0]        span_left;
		logic                      bottom_visible;
		logic                      top_visible;
		logic signed [ROW_W-1:0]   row_bottom;
		logic signed [ROW_W-1:0]   row_top;
	} span_t;

endpackage

// ----- design/efsg_mult.sv -----
// Shared multiplier of the ellipse span generator.
// Multiplies an unsigned square-sized operand by a small signed factor and wraps to ACC_BITS.
// Depends on efsg_pkg only through the defaults of its parameters.
module efsg_mult #(
	parameter int RADIUS_BITS = efsg_pkg::RADIUS_BITS_DEF,
	parameter int ACC_BITS    = efsg_pkg::ACC_BITS_DEF
) (
	input  logic [2*RADIUS_BITS:0]        op_a,
	input  logic signed [RADIUS_BITS+1:0] op_b,
	output logic signed [ACC_BITS-1:0]    prod
);

	localparam int AW = 2 * RADIUS_BITS + 2;
	localparam int PW = AW + RADIUS_BITS + 2;

	logic signed [AW-1:0] a_s;
	logic signed [PW-1:0] prod_full;

	assign a_s       = $signed({1'b0, op_a});
	assign prod_full = a_s * op_b;

	generate
		if (PW >= ACC_BITS) begin : g_trunc
			assign prod = prod_full[ACC_BITS-1:0];
		end else begin : g_sext
			assign prod = {{(ACC_BITS-PW){prod_full[PW-1]}}, prod_full};
		end
	endgenerate

endmodule

// ----- design/efsg_span.sv -----
// Span formatter of the ellipse span generator.
// Turns the current x and y into two rows with visibility flags and a clipped column range.
// Depends on efsg_pkg for field widths and the span struct.
module efsg_span #(
	parameter int RADIUS_BITS = efsg_pkg::RADIUS_BITS_DEF
) (
	input  logic signed [RADIUS_BITS+1:0]        step_x,
	input  logic signed [RADIUS_BITS+1:0]        step_y,
	input  logic signed [efsg_pkg::COORD_W-1:0]  center_x,
	input  logic signed [efsg_pkg::COORD_W-1:0]  center_y,
	input  logic [efsg_pkg::DIM_W-1:0]           image_width,
	input  logic [efsg_pkg::DIM_W-1:0]           image_height,
	input  logic [efsg_pkg::CLR_W-1:0]           color,
	output efsg_pkg::span_t                      span
);

	localparam int SW = RADIUS_BITS + 2;
	localparam int CW = ((SW > efsg_pkg::COORD_W) ? SW : efsg_pkg::COORD_W) + 2;

	logic signed [CW-1:0] x_e;
	logic signed [CW-1:0] y_e;
	logic signed [CW-1:0] ax;
	logic signed [CW-1:0] cx_e;
	logic signed [CW-1:0] cy_e;
	logic signed [CW-1:0] w_max;
	logic signed [CW-1:0] h_e;
	logic signed [CW-1:0] left_raw;
	logic signed [CW-1:0] right_raw;
	logic signed [CW-1:0] left_clip;
	logic signed [CW-1:0] right_clip;
	logic signed [CW-1:0] top_row;
	logic signed [CW-1:0] bot_row;

	always_comb begin
		x_e   = CW'(step_x);
		y_e   = CW'(step_y);
		cx_e  = CW'(center_x);
		cy_e  = CW'(center_y);
		w_max = $signed(CW'(image_width)) - $signed(CW'(1));
		h_e   = $signed(CW'(image_height));

		// The column range is symmetric, so only the magnitude of x matters.
		ax        = x_e[CW-1] ? -x_e : x_e;
		left_raw  = cx_e - ax;
		right_raw = cx_e + ax;
		left_clip  = left_raw[CW-1] ? '0 : left_raw;
		right_clip = (right_raw > w_max) ? w_max : right_raw;

		top_row = cy_e - y_e;
		bot_row = cy_e + y_e;

		span.row_top        = top_row[efsg_pkg::ROW_W-1:0];
		span.row_bottom     = bot_row[efsg_pkg::ROW_W-1:0];
		span.top_visible    = !top_row[CW-1] && (top_row < h_e);
		span.bottom_visible = !bot_row[CW-1] && (bot_row < h_e);
		span.span_left      = left_clip[efsg_pkg::COORD_W-1:0];
		span.span_right     = right_clip[efsg_pkg::ROW_W-1:0];
		span.span_color     = color;
	end

endmodule

// ----- design/filled_ellipse_span_generator_unit.sv -----
// Top level of the filled ellipse span generator.
// Holds the sequencer, the algorithm state and the output register; uses efsg_pkg,
// efsg_mult and efsg_span.

// A start word loads the centre, both radii and the fill colour and prepares the first
// stage of the midpoint ellipse algorithm; each step word then runs one pass of the
// algorithm and returns one result word, which carries a span pair (rows centre-y and
// centre+y, each flagged visible inside the image height, columns centre-x..centre+x
// clipped to the image width) when the pass produced one, and the done flag when the
// pass finished the ellipse or no ellipse is active. A stream of steps runs at one word
// per clock as long as the result side keeps up and no pass moves to stage two. The
// setup values need products of the radii, and all of them go through a single shared
// multiplier, one product per cycle: a start word keeps the input not ready while both
// squares and the x terms are formed, and the pass into stage two while the y terms are.
// The result register frees the input side, so a new word is taken in the same cycle in
// which the previous result is taken. Accumulators are ACC_BITS wide and wrap there.
// The image width and height registers may be written only while no word is in flight.
module filled_ellipse_span_generator_unit #(
	parameter int RADIUS_BITS = efsg_pkg::RADIUS_BITS_DEF,
	parameter int ACC_BITS    = efsg_pkg::ACC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input words.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata from bit 0 up: center_x, center_y, radius_x, radius_y, fill_color, zero fill.
	input  logic [efsg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// tuser: action.
	input  logic                                s_axis_tuser,
	// Result words.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata from bit 0 up: row_top, row_bottom, top_visible, bottom_visible, span_left,
	// span_right, span_color, zero fill.
	output logic [efsg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// tuser from bit 0 up: span_valid, done_res.
	output logic [efsg_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
	// Configuration writes.
	input  logic                                cfg_we,
	input  logic [efsg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [efsg_pkg::DIM_W-1:0]          cfg_data
);

	localparam int SW = RADIUS_BITS + 2;       // signed x and y counters
	localparam int TW = 2 * RADIUS_BITS + 1;   // twice a squared radius
	localparam int AW = ACC_BITS;

	// Control state.
	efsg_pkg::seq_state_t state_q, state_d;
	efsg_pkg::stage_t     stage_q;
	logic                 out_vld_q;
	logic [efsg_pkg::DIM_W-1:0] width_q, height_q;

	// Algorithm state.
	logic signed [SW-1:0] step_x_q, step_y_q;
	logic signed [AW-1:0] chg_x_q, chg_y_q, err_q, stop_x_q, stop_y_q;
	logic [TW-1:0]        tsq_a_q, tsq_b_q;
	logic signed [efsg_pkg::COORD_W-1:0] ctr_x_q, ctr_y_q;
	logic [RADIUS_BITS-1:0] rad_x_q, rad_y_q;
	logic [efsg_pkg::CLR_W-1:0] color_q;

	// Result register.
	logic [efsg_pkg::OUT_TDATA_W-1:0] out_data_q;
	logic [efsg_pkg::OUT_TUSER_W-1:0] out_user_q;

	// Input word fields.
	logic                                in_action;
	logic signed [efsg_pkg::COORD_W-1:0] in_cx, in_cy;
	logic [efsg_pkg::RAD_IN_W-1:0]       in_rx, in_ry;
	logic [efsg_pkg::CLR_W-1:0]          in_color;

	assign in_action = s_axis_tuser;
	assign in_cx     = $signed(s_axis_tdata[15:0]);
	assign in_cy     = $signed(s_axis_tdata[31:16]);
	assign in_rx     = s_axis_tdata[41:32];
	assign in_ry     = s_axis_tdata[51:42];
	assign in_color  = s_axis_tdata[83:52];

	logic accept, start_acc, step_acc;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign start_acc = accept && (in_action == efsg_pkg::ACT_START);
	assign step_acc  = accept && (in_action == efsg_pkg::ACT_STEP);

	// Twice the squared radii, and the squared y radius, extended to accumulator width.
	logic signed [AW-1:0] tsa_ext, tsb_ext, bb_ext;

	assign tsa_ext = AW'(tsq_a_q);
	assign tsb_ext = AW'(tsq_b_q);
	assign bb_ext  = AW'(tsq_b_q[TW-1:1]);

	// One pass of stage one: the error is updated with the y term first, and x steps in
	// when twice that error plus the x term turns positive.
	logic                 s1_go, s1_step;
	logic signed [AW-1:0] s1_e1;
	logic signed [AW+1:0] s1_dec;

	// One pass of stage two: x always steps out, and y steps down when twice the updated
	// error plus the y term turns positive.
	logic                 s2_go, s2_step;
	logic signed [AW-1:0] s2_e1;
	logic signed [AW+1:0] s2_dec;

	logic both_zero;

	always_comb begin
		s1_go   = stop_x_q >= stop_y_q;
		s1_e1   = err_q + chg_y_q;
		s1_dec  = {s1_e1[AW-1], s1_e1, 1'b0} + {{2{chg_x_q[AW-1]}}, chg_x_q};
		s1_step = !s1_dec[AW+1] && (s1_dec != '0);

		s2_go   = stop_x_q <= stop_y_q;
		s2_e1   = err_q + chg_x_q;
		s2_dec  = {s2_e1[AW-1], s2_e1, 1'b0} + {{2{chg_y_q[AW-1]}}, chg_y_q};
		s2_step = !s2_dec[AW+1] && (s2_dec != '0);

		both_zero = (rad_x_q == '0) && (rad_y_q == '0);
	end

	// What the current step pass does.
	logic pass_span, pass_done, pass_to_two;

	always_comb begin
		pass_span   = 1'b0;
		pass_done   = 1'b0;
		pass_to_two = 1'b0;
		case (stage_q)
			efsg_pkg::STG_ONE: begin
				// Two zero radii would never leave stage one: emit the centre once,
				// then finish on the next pass.
				if (both_zero) begin
					if (step_y_q == '0) begin
						pass_span = 1'b1;
					end else begin
						pass_done = 1'b1;
					end
				end else if (s1_go) begin
					pass_span = 1'b1;
				end else begin
					pass_to_two = 1'b1;
				end
			end
			efsg_pkg::STG_TWO: begin
				if (s2_go) begin
					pass_span = s2_step;
				end else begin
					pass_done = 1'b1;
				end
			end
			default: begin
				pass_done = 1'b1;
			end
		endcase
	end

	// Span formatting; in stage two the span uses the x after its step.
	logic signed [SW-1:0] span_x;
	efsg_pkg::span_t      span;

	assign span_x = (stage_q == efsg_pkg::STG_TWO) ? (step_x_q + SW'(1)) : step_x_q;

	efsg_span #(
		.RADIUS_BITS(RADIUS_BITS)
	) u_span (
		.step_x       (span_x),
		.step_y       (step_y_q),
		.center_x     (ctr_x_q),
		.center_y     (ctr_y_q),
		.image_width  (width_q),
		.image_height (height_q),
		.color        (color_q),
		.span         (span)
	);

	// Shared multiplier and its operand selection.
	logic [TW-1:0]        mul_a;
	logic signed [SW-1:0] mul_b;
	logic signed [AW-1:0] mul_prod;
	logic signed [SW-1:0] one_minus_2a, one_minus_2b;

	assign one_minus_2a = $signed(SW'(1)) - $signed({1'b0, rad_x_q, 1'b0});
	assign one_minus_2b = $signed(SW'(1)) - $signed({1'b0, rad_y_q, 1'b0});

	efsg_mult #(
		.RADIUS_BITS(RADIUS_BITS),
		.ACC_BITS   (ACC_BITS)
	) u_mult (
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_prod)
	);

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			efsg_pkg::SEQ_IDLE: begin
				if (start_acc) begin
					state_d = efsg_pkg::SEQ_MUL_AA;
				end else if (step_acc && pass_to_two) begin
					state_d = efsg_pkg::SEQ_MUL_CY;
				end
			end
			efsg_pkg::SEQ_MUL_AA: state_d = efsg_pkg::SEQ_MUL_BB;
			efsg_pkg::SEQ_MUL_BB: state_d = efsg_pkg::SEQ_MUL_CX;
			efsg_pkg::SEQ_MUL_CX: state_d = efsg_pkg::SEQ_MUL_SX;
			efsg_pkg::SEQ_MUL_SX: state_d = efsg_pkg::SEQ_IDLE;
			efsg_pkg::SEQ_MUL_CY: state_d = efsg_pkg::SEQ_MUL_SY;
			efsg_pkg::SEQ_MUL_SY: state_d = efsg_pkg::SEQ_IDLE;
			default:              state_d = efsg_pkg::SEQ_IDLE;
		endcase
	end

	// Sequencer: outputs (multiplier operands, ready, result load).
	logic                             out_load;
	logic [efsg_pkg::OUT_TUSER_W-1:0] out_user_d;
	logic [efsg_pkg::OUT_TDATA_W-1:0] out_data_d;

	always_comb begin
		mul_a         = '0;
		mul_b         = '0;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		out_user_d    = '0;
		out_data_d    = '0;
		case (state_q)
			efsg_pkg::SEQ_IDLE: begin
				// The result register is free, or is emptied in this cycle.
				s_axis_tready = !out_vld_q || m_axis_tready;
				if (step_acc && !pass_to_two) begin
					out_load = 1'b1;
					out_user_d[efsg_pkg::OUT_SPAN_BIT] = pass_span;
					out_user_d[efsg_pkg::OUT_DONE_BIT] = pass_done;
					if (pass_span) begin
						out_data_d = efsg_pkg::OUT_TDATA_W'({span.span_color, span.span_right,
							span.span_left, span.bottom_visible, span.top_visible,
							span.row_bottom, span.row_top});
					end
				end
			end
			efsg_pkg::SEQ_MUL_AA: begin
				mul_a = TW'(rad_x_q);
				mul_b = $signed(SW'(rad_x_q));
			end
			efsg_pkg::SEQ_MUL_BB: begin
				mul_a = TW'(rad_y_q);
				mul_b = $signed(SW'(rad_y_q));
			end
			efsg_pkg::SEQ_MUL_CX: begin
				mul_a = {1'b0, tsq_b_q[TW-1:1]};
				mul_b = one_minus_2a;
			end
			efsg_pkg::SEQ_MUL_SX: begin
				mul_a    = tsq_b_q;
				mul_b    = $signed(SW'(rad_x_q));
				out_load = 1'b1;
			end
			efsg_pkg::SEQ_MUL_CY: begin
				mul_a = {1'b0, tsq_a_q[TW-1:1]};
				mul_b = one_minus_2b;
			end
			efsg_pkg::SEQ_MUL_SY: begin
				mul_a    = tsq_a_q;
				mul_b    = $signed(SW'(rad_y_q));
				out_load = 1'b1;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= efsg_pkg::SEQ_IDLE;
			stage_q   <= efsg_pkg::STG_IDLE;
			out_vld_q <= 1'b0;
			width_q   <= efsg_pkg::WIDTH_RESET;
			height_q  <= efsg_pkg::HEIGHT_RESET;
		end else begin
			state_q <= state_d;

			if (start_acc) begin
				stage_q <= efsg_pkg::STG_ONE;
			end else if (step_acc) begin
				if (pass_done) begin
					stage_q <= efsg_pkg::STG_IDLE;
				end else if (pass_to_two) begin
					stage_q <= efsg_pkg::STG_TWO;
				end
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					efsg_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					efsg_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_d;
			out_user_q <= out_user_d;
		end
	end

	// Algorithm state updates.
	always_ff @(posedge clk) begin
		case (state_q)
			efsg_pkg::SEQ_IDLE: begin
				if (start_acc) begin
					ctr_x_q  <= in_cx;
					ctr_y_q  <= in_cy;
					rad_x_q  <= RADIUS_BITS'(in_rx);
					rad_y_q  <= RADIUS_BITS'(in_ry);
					color_q  <= in_color;
					step_x_q <= $signed(SW'(RADIUS_BITS'(in_rx)));
					step_y_q <= '0;
					err_q    <= '0;
					stop_y_q <= '0;
				end else if (step_acc) begin
					case (stage_q)
						efsg_pkg::STG_ONE: begin
							if (both_zero) begin
								if (step_y_q == '0) begin
									step_y_q <= SW'(1);
								end
							end else if (s1_go) begin
								step_y_q <= step_y_q + SW'(1);
								stop_y_q <= stop_y_q + tsa_ext;
								chg_y_q  <= chg_y_q + tsa_ext;
								if (s1_step) begin
									step_x_q <= step_x_q - SW'(1);
									stop_x_q <= stop_x_q - tsb_ext;
									err_q    <= s1_e1 + chg_x_q;
									chg_x_q  <= chg_x_q + tsb_ext;
								end else begin
									err_q <= s1_e1;
								end
							end else begin
								// Stage two starts at the top of the ellipse; the y terms
								// follow from the multiplier.
								step_x_q <= '0;
								step_y_q <= $signed(SW'(rad_y_q));
								chg_x_q  <= bb_ext;
								err_q    <= '0;
								stop_x_q <= '0;
							end
						end
						efsg_pkg::STG_TWO: begin
							if (s2_go) begin
								step_x_q <= step_x_q + SW'(1);
								stop_x_q <= stop_x_q + tsb_ext;
								chg_x_q  <= chg_x_q + tsb_ext;
								if (s2_step) begin
									step_y_q <= step_y_q - SW'(1);
									stop_y_q <= stop_y_q - tsa_ext;
									err_q    <= s2_e1 + chg_y_q;
									chg_y_q  <= chg_y_q + tsa_ext;
								end else begin
									err_q <= s2_e1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			efsg_pkg::SEQ_MUL_AA: begin
				tsq_a_q <= {mul_prod[2*RADIUS_BITS-1:0], 1'b0};
				chg_y_q <= mul_prod;
			end
			efsg_pkg::SEQ_MUL_BB: begin
				tsq_b_q <= {mul_prod[2*RADIUS_BITS-1:0], 1'b0};
			end
			efsg_pkg::SEQ_MUL_CX: chg_x_q  <= mul_prod;
			efsg_pkg::SEQ_MUL_SX: stop_x_q <= mul_prod;
			efsg_pkg::SEQ_MUL_CY: chg_y_q  <= mul_prod;
			efsg_pkg::SEQ_MUL_SY: stop_y_q <= mul_prod;
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

// ----- design/efsg_checker.sv -----
// Port-level checks for the filled ellipse span generator, bound to its top level.
// Depends on efsg_pkg for widths and codes.
module efsg_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                s_axis_tuser,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [efsg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input logic [efsg_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

	// A stalled result word holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// A pass never both produces a span and finishes the ellipse.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			!(m_axis_tuser[efsg_pkg::OUT_SPAN_BIT] && m_axis_tuser[efsg_pkg::OUT_DONE_BIT]))
		else $error("span and done flagged together");

	// A result without a span carries an all-zero payload.
	a_nospan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[efsg_pkg::OUT_SPAN_BIT] |-> m_axis_tdata == '0)
		else $error("payload not cleared on a result without span");

	// The setup products keep the input busy after a start word.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == efsg_pkg::ACT_START)
			|=> !s_axis_tready)
		else $error("input ready right after a start word");

endmodule

bind filled_ellipse_span_generator_unit efsg_checker u_efsg_checker (.*);
